### sv/seven_segment_display_writer_core_assert.svh
// Assertion macros shared by the display writer RTL.
`ifndef SEVEN_SEGMENT_DISPLAY_WRITER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_DISPLAY_WRITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SSDW_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("assertion failed");
`define SSDW_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition seen");
`else
`define SSDW_ASSERT(lbl, clk, rstn, prop)
`define SSDW_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### sv/ssdw_pkg.sv
// Types, codes and segment tables of the seven-segment display writer.
package ssdw_pkg;

	localparam int unsigned SEG_W = 7;
	localparam int unsigned STORE_SLOTS = 8;
	// floor(n / 10) == (n * RECIP10) >> RECIP_SHIFT for every 16-bit n.
	localparam logic [15:0] RECIP10 = 16'd52429;
	localparam int unsigned RECIP_SHIFT = 19;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_DEC    = 2'd1,
		OP_LETTER = 2'd2,
		OP_HEX    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_REM,
		ST_DONE
	} state_t;

	typedef logic [SEG_W-1:0] seg_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  start_req;
		logic [3:0]  length;
		logic [15:0] value;
	} in_t;

	typedef struct packed {
		seg_t digit0;
		seg_t digit1;
		seg_t digit2;
		seg_t digit3;
		seg_t digit4;
		seg_t digit5;
		seg_t digit6;
		seg_t digit7;
	} out_t;

	localparam seg_t DIGIT_PAT [16] = '{
		7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7,
		7'd127, 7'd111, 7'd119, 7'd124, 7'd88, 7'd94, 7'd121, 7'd113
	};

	localparam seg_t LETTER_PAT [26] = '{
		7'd119, 7'd124, 7'd88, 7'd94, 7'd121, 7'd113, 7'd61, 7'd116,
		7'd48, 7'd13, 7'd117, 7'd56, 7'd85, 7'd84, 7'd92, 7'd115,
		7'd103, 7'd80, 7'd45, 7'd120, 7'd28, 7'd42, 7'd106, 7'd20,
		7'd110, 7'd27
	};

endpackage

### sv/ssdw_div.sv
// Shared divide-by-base unit: registered quotient, remainder derived combinationally from it.
module ssdw_div (
	input  logic        clk,
	input  logic        en,
	input  logic        hex,
	input  logic [15:0] dividend,
	output logic [15:0] quotient,
	output logic [3:0]  remainder
);

	logic [31:0] prod;
	logic [15:0] quo_q;
	logic [15:0] times10;

	assign prod = 32'(dividend) * 32'(ssdw_pkg::RECIP10);

	always_ff @(posedge clk) begin
		if (en) begin
			if (hex) begin
				quo_q <= {4'd0, dividend[15:4]};
			end else begin
				quo_q <= 16'(prod[31:ssdw_pkg::RECIP_SHIFT]);
			end
		end
	end

	// The dividend is held by the caller until the remainder has been used.
	assign times10 = 16'({quo_q, 3'd0}) + 16'({quo_q, 1'd0});
	assign quotient = quo_q;
	assign remainder = hex ? dividend[3:0] : 4'(dividend - times10);

endmodule

### sv/seven_segment_display_writer_core.sv
// Top level of the seven-segment display writer: command sequencer and digit store.
// Each accepted command word updates an eight-digit store and then yields one result word
// holding all eight segment patterns. Clear and letter commands pass from acceptance straight
// to the done state, which loads the result into the output register. A number command of
// nonzero length first alternates a divide state and a remainder state for each digit: the
// digits are produced least significant first by a single shared divide-by-base unit
// (registered quotient, then remainder and store write). The block is ready again the cycle
// after a result is loaded; the done state waits while an earlier result is not yet taken.
// The block takes one command at a time; a finished result waits in an output register,
// so a new command is accepted while that result is still waiting to be taken.
`include "seven_segment_display_writer_core_assert.svh"

module seven_segment_display_writer_core #(
	parameter int unsigned DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ssdw_pkg::in_t     in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ssdw_pkg::out_t    out_data
);

	ssdw_pkg::state_t state_q, state_d;
	ssdw_pkg::seg_t   store_q [ssdw_pkg::STORE_SLOTS];
	logic [1:0]  op_q;
	logic [2:0]  start_q;
	logic [3:0]  len_q;
	logic [3:0]  k_q;
	logic [15:0] rest_q;
	logic        out_valid_q;
	ssdw_pkg::out_t out_q;

	logic        accept;
	logic        div_en;
	logic        wr_num;
	logic        load_out;
	logic [15:0] quotient;
	logic [3:0]  remainder;
	logic [4:0]  num_pos;
	logic [7:0]  ch;
	logic        ch_ok;
	logic [4:0]  ch_idx;
	logic        is_number;

	assign accept = in_valid && in_ready;
	assign is_number = (in_data.operation == ssdw_pkg::OP_DEC) ||
		(in_data.operation == ssdw_pkg::OP_HEX);
	assign ch = in_data.value[7:0];
	assign ch_ok = ch inside {[8'h61:8'h7A]};
	assign ch_idx = 5'(ch - 8'h61);
	assign num_pos = 5'({2'd0, start_q}) + 5'({1'd0, len_q}) - 5'd1 - 5'({1'd0, k_q});

	ssdw_div u_div (
		.clk       (clk),
		.en        (div_en),
		.hex       (op_q == ssdw_pkg::OP_HEX),
		.dividend  (rest_q),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssdw_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_number && in_data.length != 4'd0) begin
						state_d = ssdw_pkg::ST_DIV;
					end else begin
						state_d = ssdw_pkg::ST_DONE;
					end
				end
			end
			ssdw_pkg::ST_DIV: state_d = ssdw_pkg::ST_REM;
			ssdw_pkg::ST_REM: begin
				if (k_q == len_q - 4'd1) begin
					state_d = ssdw_pkg::ST_DONE;
				end else begin
					state_d = ssdw_pkg::ST_DIV;
				end
			end
			ssdw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ssdw_pkg::ST_IDLE;
				end
			end
			default: state_d = ssdw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_en = 1'b0;
		wr_num = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ssdw_pkg::ST_IDLE: in_ready = 1'b1;
			ssdw_pkg::ST_DIV:  div_en = 1'b1;
			ssdw_pkg::ST_REM:  wr_num = 1'b1;
			ssdw_pkg::ST_DONE: load_out = !out_valid_q || out_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssdw_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_data.operation;
			start_q <= in_data.start_req;
			len_q <= in_data.length;
			rest_q <= in_data.value;
			k_q <= 4'd0;
		end else if (wr_num) begin
			rest_q <= quotient;
			k_q <= k_q + 4'd1;
		end
	end

	// Slots at or beyond DIGITS are never written, so they stay zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssdw_pkg::STORE_SLOTS; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ssdw_pkg::STORE_SLOTS; i++) begin
				if (i < DIGITS) begin
					if (accept && in_data.operation == ssdw_pkg::OP_CLEAR) begin
						store_q[i] <= '0;
					end else if (accept && in_data.operation == ssdw_pkg::OP_LETTER &&
							ch_ok && in_data.start_req == 3'(i)) begin
						store_q[i] <= ssdw_pkg::LETTER_PAT[ch_idx];
					end else if (wr_num && num_pos == 5'(i)) begin
						store_q[i] <= ssdw_pkg::DIGIT_PAT[remainder];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.digit0 <= store_q[0];
			out_q.digit1 <= store_q[1];
			out_q.digit2 <= store_q[2];
			out_q.digit3 <= store_q[3];
			out_q.digit4 <= store_q[4];
			out_q.digit5 <= store_q[5];
			out_q.digit6 <= store_q[6];
			out_q.digit7 <= store_q[7];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`SSDW_ASSERT(a_number_starts, clk, arst_n, accept && is_number && in_data.length != 4'd0 |=> state_q == ssdw_pkg::ST_DIV)
	`SSDW_ASSERT(a_rem_next, clk, arst_n, state_q == ssdw_pkg::ST_REM |=> state_q == ssdw_pkg::ST_DIV || state_q == ssdw_pkg::ST_DONE)
	`SSDW_NEVER(a_digit_count, clk, arst_n, state_q == ssdw_pkg::ST_REM && k_q >= len_q)
	`SSDW_ASSERT(a_clear_zeroes, clk, arst_n, accept && in_data.operation == ssdw_pkg::OP_CLEAR |=> store_q[0] == '0)

endmodule
